/* rtl/sitda_pkg.sv */
package sitda_pkg;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned NumDigits     = 10;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned NumStages     = ValueWidth / StepsPerStage;
  localparam int unsigned DigitIdxWidth = $clog2(NumDigits);

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // double-dabble correction: a digit of five or more gets three added before the shift
  localparam logic [3:0] DigitAdjMin = 4'd5;
  localparam logic [3:0] DigitAdj    = 4'd3;

  typedef logic [NumDigits-1:0][3:0] digits_t;

  typedef struct packed {
    logic                  neg;
    logic [ValueWidth-1:0] mag;
    digits_t               digits;
  } beat_t;

endpackage

/* rtl/sitda_abs.sv */
module sitda_abs (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  logic signed [sitda_pkg::ValueWidth-1:0] value_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output sitda_pkg::beat_t                        data_o
);

  logic             valid_q;
  sitda_pkg::beat_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.neg    = value_i[sitda_pkg::ValueWidth-1];
    // unsigned negate: the most negative value maps to its exact magnitude
    data_d.mag    = data_d.neg ? (sitda_pkg::ValueWidth'(0) - $unsigned(value_i))
                               : $unsigned(value_i);
    data_d.digits = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/sitda_dabble.sv */
module sitda_dabble (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  sitda_pkg::beat_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output sitda_pkg::beat_t data_o
);

  logic             valid_q;
  sitda_pkg::beat_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  // shift StepsPerStage magnitude bits into the BCD digits, msb first
  always_comb begin
    data_d = data_i;
    for (int s = 0; s < sitda_pkg::StepsPerStage; s++) begin
      for (int d = 0; d < sitda_pkg::NumDigits; d++) begin
        if (data_d.digits[d] >= sitda_pkg::DigitAdjMin) begin
          data_d.digits[d] = data_d.digits[d] + sitda_pkg::DigitAdj;
        end
      end
      for (int d = sitda_pkg::NumDigits - 1; d > 0; d--) begin
        data_d.digits[d] = {data_d.digits[d][2:0], data_d.digits[d-1][3]};
      end
      data_d.digits[0] = {data_d.digits[0][2:0], data_d.mag[sitda_pkg::ValueWidth-1]};
      data_d.mag       = {data_d.mag[sitda_pkg::ValueWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/sitda_ser.sv */
module sitda_ser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  sitda_pkg::beat_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [7:0]       char_o,
  output logic             last_o
);

  logic                                busy_d, busy_q;
  logic                                sign_d, sign_q;
  logic [sitda_pkg::DigitIdxWidth-1:0] idx_d, idx_q;
  logic [sitda_pkg::DigitIdxWidth-1:0] msd;
  sitda_pkg::digits_t                  digits_d, digits_q;
  logic                                out_valid_d, out_valid_q;
  logic [7:0]                          char_d, char_q;
  logic                                last_d, last_q;
  logic                                out_free;

  assign ready_o  = !busy_q;
  assign out_free = !out_valid_q || ready_i;

  // highest nonzero digit; zero keeps a single digit
  always_comb begin
    msd = '0;
    for (int d = 1; d < sitda_pkg::NumDigits; d++) begin
      if (data_i.digits[d] != 4'd0) begin
        msd = sitda_pkg::DigitIdxWidth'(d);
      end
    end
  end

  always_comb begin
    busy_d      = busy_q;
    sign_d      = sign_q;
    idx_d       = idx_q;
    digits_d    = digits_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (!busy_q) begin
      if (ready_i) begin
        out_valid_d = 1'b0;
      end
      if (valid_i) begin
        busy_d   = 1'b1;
        sign_d   = data_i.neg;
        idx_d    = msd;
        digits_d = data_i.digits;
      end
    end else if (out_free) begin
      out_valid_d = 1'b1;
      if (sign_q) begin
        // emit the minus sign before the digits
        char_d = sitda_pkg::CharMinus;
        last_d = 1'b0;
        sign_d = 1'b0;
      end else begin
        char_d = sitda_pkg::CharZero + {4'd0, digits_q[idx_q]};
        last_d = (idx_q == '0);
        if (idx_q == '0) begin
          busy_d = 1'b0;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      sign_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      sign_q      <= sign_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    char_q   <= char_d;
    last_q   <= last_d;
  end

  assign valid_o = out_valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// Signed 32-bit integer to decimal ASCII text.
// Slave stream: one beat carries one two's complement value in s_axis_tdata.
// Master stream: one beat per character, most significant first: '-' for a
// negative value, then the digits without leading zeros; m_axis_tlast marks
// the final character. One value gives 1 to 11 beats.
// A value passes a register for the magnitude, eight double-dabble stages
// of four bits each and a load register into the character serializer.
// The serializer holds one value at a time and sends one character per
// cycle while the receiver is ready; it takes a new value only once it has
// sent the last character of the previous one, so it sets the throughput.
// The conversion stages keep accepting values while the serializer works,
// until they fill up.
// Reset clears all valid bits; nothing is kept between values.
// When the receiver stalls, the current character holds in the output
// register and backpressure fills the stages and then drops s_axis_tready;
// nothing is lost or repeated.
module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] character
  output logic        m_axis_tlast    // last
);

  logic             valid_s [sitda_pkg::NumStages+1];
  logic             ready_s [sitda_pkg::NumStages+1];
  sitda_pkg::beat_t data_s  [sitda_pkg::NumStages+1];

  sitda_abs u_abs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .value_i ($signed(s_axis_tdata)),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .data_o  (data_s[0])
  );

  for (genvar g = 0; g < sitda_pkg::NumStages; g++) begin : g_dabble
    sitda_dabble u_dabble (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[g]),
      .ready_o (ready_s[g]),
      .data_i  (data_s[g]),
      .valid_o (valid_s[g+1]),
      .ready_i (ready_s[g+1]),
      .data_o  (data_s[g+1])
    );
  end

  sitda_ser u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[sitda_pkg::NumStages]),
    .ready_o (ready_s[sitda_pkg::NumStages]),
    .data_i  (data_s[sitda_pkg::NumStages]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .char_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

endmodule

/* rtl/sitda_checker.sv */
module sitda_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata == sitda_pkg::CharMinus ||
      (m_axis_tdata >= sitda_pkg::CharZero && m_axis_tdata <= sitda_pkg::CharZero + 8'd9))
    else $error("output character is neither a digit nor a minus sign");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata == sitda_pkg::CharMinus |-> !m_axis_tlast)
    else $error("minus sign marked as last character");

  // check only while reset stays low over consecutive edges, once the valid bits have cleared
  assert property (@(posedge clk_i)
    !rst_ni ##1 !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
